### rtl/core/fisr_pkg.sv
`timescale 1ns / 1ps
package fisr_pkg;

   // first guess constant and binary32 constants of the Newton step
   localparam logic [31:0] GUESS_MAGIC = 32'h5f3759df;
   localparam logic [31:0] FP_HALF     = 32'h3f000000;
   localparam logic [31:0] FP_ONE_HALF = 32'h3fc00000;
   localparam logic [31:0] FP_QNAN     = 32'hffc00000;
   localparam logic [31:0] FP_QUIET    = 32'h00400000;

   // latency of one arithmetic unit and of the whole datapath
   localparam int UNIT_DEPTH = 3;
   localparam int PIPE_DEPTH = 5 * UNIT_DEPTH;
   localparam int YDL_DEPTH  = 4 * UNIT_DEPTH;

   // count leading zeros of a 48-bit word, 48 when all zero
   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] res;
      logic       found;
      res   = 6'd48;
      found = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (!found && v[i]) begin
            res   = 6'(47 - i);
            found = 1'b1;
         end
      end
      return res;
   endfunction

endpackage

### rtl/core/fisr_fmul.sv
`timescale 1ns / 1ps
module fisr_fmul import fisr_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] p
);

   // unpack operands
   logic [7:0]  ea, eb;
   logic [23:0] ma, mb;
   logic        anan, bnan, ainf, binf, azero, bzero, sgn;
   logic        spec_in;
   logic [31:0] sval_in;

   always_comb begin
      ea    = a[30:23];
      eb    = b[30:23];
      ma    = {ea != 8'd0, a[22:0]};
      mb    = {eb != 8'd0, b[22:0]};
      anan  = (ea == 8'hff) && (a[22:0] != 23'd0);
      bnan  = (eb == 8'hff) && (b[22:0] != 23'd0);
      ainf  = (ea == 8'hff) && (a[22:0] == 23'd0);
      binf  = (eb == 8'hff) && (b[22:0] == 23'd0);
      azero = a[30:0] == 31'd0;
      bzero = b[30:0] == 31'd0;
      sgn   = a[31] ^ b[31];
      spec_in = 1'b1;
      priority if (anan)                            sval_in = a | FP_QUIET;
      else if (bnan)                                sval_in = b | FP_QUIET;
      else if ((ainf && bzero) || (binf && azero))  sval_in = FP_QNAN;
      else if (ainf || binf)                        sval_in = {sgn, 8'hff, 23'd0};
      else if (azero || bzero)                      sval_in = {sgn, 31'd0};
      else begin
         spec_in = 1'b0;
         sval_in = 32'd0;
      end
   end

   // stage 1: mantissa product and exponent sum
   logic [47:0]        p1_ff;
   logic signed [10:0] e1_ff;
   logic               s1_ff, spec1_ff;
   logic [31:0]        sval1_ff;
   logic [7:0]         eaf, ebf;

   assign eaf = (ea == 8'd0) ? 8'd1 : ea;
   assign ebf = (eb == 8'd0) ? 8'd1 : eb;

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff    <= ma * mb;
         e1_ff    <= $signed({3'b0, eaf}) + $signed({3'b0, ebf}) - 11'sd127;
         s1_ff    <= sgn;
         spec1_ff <= spec_in;
         sval1_ff <= sval_in;
      end
   end

   // stage 2: normalize leading one to the top bit
   logic [5:0]         lz;
   logic [47:0]        pn2_ff;
   logic signed [10:0] er2_ff;
   logic               s2_ff, spec2_ff;
   logic [31:0]        sval2_ff;

   assign lz = lzc48(p1_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         pn2_ff   <= p1_ff << lz;
         er2_ff   <= e1_ff + 11'sd1 - $signed({5'b0, lz});
         s2_ff    <= s1_ff;
         spec2_ff <= spec1_ff;
         sval2_ff <= sval1_ff;
      end
   end

   // stage 3: denormalize if needed and round to nearest even
   logic signed [10:0] kraw;
   logic [5:0]         k;
   logic [7:0]         expf;
   logic [95:0]        wide;
   logic [47:0]        q;
   logic [22:0]        mant;
   logic               g, st, up;
   logic [30:0]        mag;
   logic [31:0]        p3_ff;

   always_comb begin
      kraw = 11'sd1 - er2_ff;
      if (er2_ff >= 11'sd1) begin
         k    = 6'd0;
         expf = er2_ff[7:0];
      end else begin
         k    = (kraw > 11'sd49) ? 6'd49 : kraw[5:0];
         expf = 8'd0;
      end
      wide = {pn2_ff, 48'd0} >> k;
      q    = wide[95:48];
      mant = q[46:24];
      g    = q[23];
      st   = (|q[22:0]) | (|wide[47:0]);
      up   = g & (st | mant[0]);
      mag  = {expf, mant} + {30'd0, up};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (spec2_ff)                 p3_ff <= sval2_ff;
         else if (er2_ff >= 11'sd255)  p3_ff <= {s2_ff, 8'hff, 23'd0};
         else                          p3_ff <= {s2_ff, mag};
      end
   end

   assign p = p3_ff;

endmodule

### rtl/core/fisr_fsub.sv
`timescale 1ns / 1ps
module fisr_fsub import fisr_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] d
);

   // unpack, flip sign of b, order operands by magnitude
   logic        sbn, anan, bnan, ainf, binf, swap, spec_in;
   logic [31:0] sval_in;
   logic [30:0] big, sml;
   logic [7:0]  ebf, esf;

   always_comb begin
      sbn  = ~b[31];
      anan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
      bnan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
      ainf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
      binf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
      swap = b[30:0] > a[30:0];
      big  = swap ? b[30:0] : a[30:0];
      sml  = swap ? a[30:0] : b[30:0];
      ebf  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      esf  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      spec_in = 1'b1;
      priority if (anan)                         sval_in = a | FP_QUIET;
      else if (bnan)                             sval_in = b | FP_QUIET;
      else if (ainf && binf && (a[31] != sbn))   sval_in = FP_QNAN;
      else if (ainf)                             sval_in = a;
      else if (binf)                             sval_in = {sbn, 8'hff, 23'd0};
      else begin
         spec_in = 1'b0;
         sval_in = 32'd0;
      end
   end

   // stage 1: operands in magnitude order
   logic [23:0] mb1_ff, ms1_ff;
   logic [7:0]  e1_ff, dd1_ff;
   logic        s1_ff, sub1_ff, zs1_ff, spec1_ff;
   logic [31:0] sval1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         mb1_ff   <= {big[30:23] != 8'd0, big[22:0]};
         ms1_ff   <= {sml[30:23] != 8'd0, sml[22:0]};
         e1_ff    <= ebf;
         dd1_ff   <= ebf - esf;
         s1_ff    <= swap ? sbn : a[31];
         sub1_ff  <= a[31] ^ sbn;
         zs1_ff   <= a[31] & sbn;
         spec1_ff <= spec_in;
         sval1_ff <= sval_in;
      end
   end

   // stage 2: align smaller operand with sticky, add or subtract
   logic [4:0]  dsh;
   logic [53:0] wide;
   logic [26:0] al, bg;
   logic [27:0] sum2_ff;
   logic [7:0]  e2_ff;
   logic        s2_ff, zs2_ff, spec2_ff;
   logic [31:0] sval2_ff;

   always_comb begin
      dsh  = (dd1_ff > 8'd28) ? 5'd28 : dd1_ff[4:0];
      wide = {ms1_ff, 3'b0, 27'd0} >> dsh;
      al   = {wide[53:28], wide[27] | (|wide[26:0])};
      bg   = {mb1_ff, 3'b0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum2_ff  <= sub1_ff ? ({1'b0, bg} - {1'b0, al}) : ({1'b0, bg} + {1'b0, al});
         e2_ff    <= e1_ff;
         s2_ff    <= s1_ff;
         zs2_ff   <= zs1_ff;
         spec2_ff <= spec1_ff;
         sval2_ff <= sval1_ff;
      end
   end

   // stage 3: normalize, round to nearest even
   logic [5:0]  lz, sh;
   logic [26:0] n;
   logic [8:0]  expw;
   logic [7:0]  expf;
   logic [22:0] mant;
   logic        g, st, up;
   logic [30:0] mag;
   logic [31:0] d3_ff;

   always_comb begin
      lz = lzc48({sum2_ff[26:0], 21'd0});
      sh = (lz > 6'(e2_ff - 8'd1)) ? 6'(e2_ff - 8'd1) : lz;
      if (e2_ff - 8'd1 > 8'd27) sh = lz;
      if (sum2_ff[27]) begin
         n    = {sum2_ff[27:2], sum2_ff[1] | sum2_ff[0]};
         expw = {1'b0, e2_ff} + 9'd1;
      end else begin
         n    = sum2_ff[26:0] << sh;
         expw = n[26] ? ({1'b0, e2_ff} - {3'b0, sh}) : 9'd0;
      end
      expf = expw[7:0];
      mant = n[25:3];
      g    = n[2];
      st   = |n[1:0];
      up   = g & (st | mant[0]);
      mag  = {expf, mant} + {30'd0, up};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (spec2_ff)              d3_ff <= sval2_ff;
         else if (sum2_ff == 28'd0) d3_ff <= {zs2_ff, 31'd0};
         else if (expw >= 9'd255)   d3_ff <= {s2_ff, 8'hff, 23'd0};
         else                       d3_ff <= {s2_ff, mag};
      end
   end

   assign d = d3_ff;

endmodule

### rtl/core/fast_inverse_square_root_unit.sv
`timescale 1ns / 1ps
// Fast reciprocal square root of a binary32 value.
// Input channel: req_valid / req_stall / req_x_bits, the input bit pattern.
// Result channel: rsp_valid / rsp_stall / rsp_y_bits, the approximation.
// A transaction completes on a rising edge with valid high and stall low.
// The first guess is the magic word minus the input shifted right by one;
// one Newton step follows as separate binary32 operations with
// round-to-nearest-even: four multipliers and one subtractor in a chain.
// The datapath is five arithmetic units of three register stages each.
// Throughput: one transaction per cycle while the receiver takes results.
// When rsp_stall holds a valid result, the whole pipeline freezes and
// req_stall rises in the same cycle; nothing is lost or repeated.
// Reset (synchronous, active high) clears all valid bits; the data
// registers are not reset.
module fast_inverse_square_root_unit import fisr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_x_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_y_bits
);

   logic                  en;
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic [31:0]           ydl_ff [YDL_DEPTH];
   logic [31:0]           y0, half, t1, t2, t3;

   // freeze everything while a result waits at the output
   assign en        = !(vld_ff[PIPE_DEPTH-1] && rsp_stall);
   assign req_stall = !en;

   // first guess from the integer trick
   assign y0 = GUESS_MAGIC - {1'b0, req_x_bits[31:1]};

   // advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   // carry the guess along to each unit that needs it
   always_ff @(posedge clock) begin
      if (en) begin
         ydl_ff[0] <= y0;
         for (int i = 1; i < YDL_DEPTH; i++) begin
            ydl_ff[i] <= ydl_ff[i-1];
         end
      end
   end

   fisr_fmul u_half (.clock(clock), .en(en), .a(FP_HALF), .b(req_x_bits), .p(half));
   fisr_fmul u_t1 (.clock(clock), .en(en), .a(half), .b(ydl_ff[UNIT_DEPTH-1]), .p(t1));
   fisr_fmul u_t2 (.clock(clock), .en(en), .a(t1), .b(ydl_ff[2*UNIT_DEPTH-1]), .p(t2));
   fisr_fsub u_t3 (.clock(clock), .en(en), .a(FP_ONE_HALF), .b(t2), .d(t3));
   fisr_fmul u_r (.clock(clock), .en(en), .a(ydl_ff[YDL_DEPTH-1]), .b(t3), .p(rsp_y_bits));

   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

endmodule

### rtl/core/fisr_checker.sv
`timescale 1ns / 1ps
module fisr_checker import fisr_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [31:0] req_x_bits,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_y_bits
);

   // no result right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // held result keeps its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_y_bits))
      else $error("stalled result changed");

   // input is stalled exactly when a result is held
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output hold");

   // no result before the pipeline can have filled after reset
   a_no_invent: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid [*PIPE_DEPTH])
      else $error("unexpected result");

endmodule

bind fast_inverse_square_root_unit fisr_checker u_fisr_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_x_bits(req_x_bits),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_y_bits(rsp_y_bits)
);

### dv/rsqrt_checker.sv
`timescale 1ns / 1ps
module rsqrt_checker import fisr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_x_bits,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_y_bits,
   output int          fail_count,
   output int          pending,
   output int          seen_count
);

   logic [31:0] expected_y_q[$];

   function automatic bit is_nan(input logic [31:0] a);
      return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
   endfunction

   function automatic bit is_inf(input logic [31:0] a);
      return a[30:0] == 31'h7f800000;
   endfunction

   function automatic bit is_zero(input logic [31:0] a);
      return a[30:0] == 31'd0;
   endfunction

   // split a finite value into an integer significand and a power of two
   function automatic void unpack_fp(input logic [31:0] a, output logic [63:0] sig,
                                     output int e);
      if (a[30:23] == 8'd0) begin
         sig = {41'd0, a[22:0]};
         e   = -149;
      end else begin
         sig = {40'd0, 1'b1, a[22:0]};
         e   = int'(a[30:23]) - 150;
      end
   endfunction

   // round sig * 2^e to binary32, nearest even, with gradual underflow
   function automatic logic [31:0] round_fp(input bit s, input int e, input logic [63:0] sig);
      int          p;
      int          sh;
      int          be;
      logic [63:0] m;
      bit          guard;
      bit          sticky;
      p = 0;
      for (int i = 0; i < 64; i++) if (sig[i]) p = i;
      sh = p - 23;
      if (-149 - e > sh) sh = -149 - e;
      if (sh > 0) begin
         m      = (sh >= 64) ? 64'd0 : sig >> sh;
         guard  = (sh > 64) ? 1'b0 : sig[sh-1];
         sticky = (sh - 1 >= 64) ? |sig : |(sig & ((64'd1 << (sh - 1)) - 64'd1));
         if (guard && (sticky || m[0])) m = m + 64'd1;
      end else begin
         m = sig << (-sh);
      end
      if (m == (64'd1 << 24)) begin
         m  = 64'd1 << 23;
         sh = sh + 1;
      end
      be = sh + e + 150;
      if (m >= (64'd1 << 23)) begin
         if (be >= 255) return {s, 8'hff, 23'd0};
         return {s, be[7:0], m[22:0]};
      end
      return {s, 8'h00, m[22:0]};
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] sa;
      logic [63:0] sb;
      int          ea;
      int          eb;
      bit          s;
      if (is_nan(a)) return a | FP_QUIET;
      if (is_nan(b)) return b | FP_QUIET;
      s = a[31] ^ b[31];
      if (is_inf(a)) return is_zero(b) ? FP_QNAN : {s, 31'h7f800000};
      if (is_inf(b)) return is_zero(a) ? FP_QNAN : {s, 31'h7f800000};
      if (is_zero(a) || is_zero(b)) return {s, 31'd0};
      unpack_fp(a, sa, ea);
      unpack_fp(b, sb, eb);
      return round_fp(s, ea + eb, sa * sb);
   endfunction

   function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] nb;
      logic [31:0] big;
      logic [31:0] sml;
      logic [63:0] sg_big;
      logic [63:0] sg_sml;
      logic [63:0] mag;
      int          e_big;
      int          e_sml;
      int          d;
      bit          same;
      if (is_nan(a)) return a | FP_QUIET;
      if (is_nan(b)) return b | FP_QUIET;
      nb = {~b[31], b[30:0]};
      if (is_inf(a) && is_inf(nb)) return (a[31] != nb[31]) ? FP_QNAN : a;
      if (is_inf(a)) return a;
      if (is_inf(nb)) return nb;
      if (is_zero(a) && is_zero(nb)) return {a[31] & nb[31], 31'd0};
      if (is_zero(a)) return nb;
      if (is_zero(nb)) return a;
      // order by magnitude; the bit patterns sort like the values
      if (a[30:0] >= nb[30:0]) begin
         big = a;
         sml = nb;
      end else begin
         big = nb;
         sml = a;
      end
      same = big[31] == sml[31];
      unpack_fp(big, sg_big, e_big);
      unpack_fp(sml, sg_sml, e_sml);
      d = e_big - e_sml;
      if (d >= 36) begin
         // smaller operand only acts as a sticky bit
         mag = same ? (sg_big << 3) + 64'd1 : (sg_big << 3) - 64'd1;
         return round_fp(big[31], e_big - 3, mag);
      end
      mag = same ? (sg_big << d) + sg_sml : (sg_big << d) - sg_sml;
      if (mag == 64'd0) return 32'd0;
      return round_fp(big[31], e_sml, mag);
   endfunction

   // guess from the magic word, then one Newton step
   function automatic logic [31:0] rsqrt_approx(input logic [31:0] x);
      logic [31:0] half;
      logic [31:0] y;
      logic [31:0] t1;
      logic [31:0] t2;
      logic [31:0] t3;
      half = fp_mul(FP_HALF, x);
      y    = GUESS_MAGIC - (x >> 1);
      t1   = fp_mul(half, y);
      t2   = fp_mul(t1, y);
      t3   = fp_sub(FP_ONE_HALF, t2);
      return fp_mul(y, t3);
   endfunction

   assign pending = expected_y_q.size();

   // predict on every accepted request, compare every accepted response
   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         fail_count <= 0;
         seen_count <= 0;
      end else begin
         if (req_valid && !req_stall) expected_y_q.push_back(rsqrt_approx(req_x_bits));
         if (rsp_valid && !rsp_stall) begin
            seen_count <= seen_count + 1;
            if (expected_y_q.size() == 0) begin
               $display("%0t: unexpected transaction, y_bits actual %h", $time, rsp_y_bits);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_y_q.pop_front();
               if (want !== rsp_y_bits) begin
                  $display("%0t: y_bits mismatch, expected %h actual %h", $time, want,
                           rsp_y_bits);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
module testbench;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_x_bits;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_y_bits;
   int          fail_count;
   int          pending;
   int          seen_count;
   int          stall_pct;
   logic [31:0] x_list[$];

   fast_inverse_square_root_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_x_bits(req_x_bits),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_y_bits(rsp_y_bits)
   );

   rsqrt_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_x_bits(req_x_bits),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_y_bits(rsp_y_bits),
      .fail_count(fail_count), .pending(pending), .seen_count(seen_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // random backpressure on the response side
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // pick an input: raw bits, special exponents, or ordinary positive values
   function automatic logic [31:0] pick_x();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(9))
         0, 1, 2: return r;
         3:       return {r[31], 8'h00, r[22:0]};
         4:       return {r[31], 8'hff, r[22:0]};
         5:       return {r[31], 8'hff, 23'd0};
         default: return {1'b0, 8'(96 + $urandom_range(60)), r[22:0]};
      endcase
   endfunction

   // send every queued x; hold payload while stalled
   task automatic send_phase(input int idle_pct, input int rsp_pct, input int count);
      int sent;
      stall_pct = rsp_pct;
      sent = 0;
      while (sent < count) begin
         @(posedge clock);
         if (req_valid && !req_stall) sent++;
         if (!(req_valid && req_stall)) begin
            if (sent < count && $urandom_range(99) >= idle_pct) begin
               req_valid  <= 1'b1;
               req_x_bits <= x_list.pop_front();
            end else begin
               req_valid  <= 1'b0;
               req_x_bits <= $urandom();
            end
         end
      end
   endtask

   initial begin
      req_valid  = 1'b0;
      req_x_bits = 32'd0;
      stall_pct  = 0;
      reset      = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // extremes, signed zeros, infinities, NaNs, subnormals, negatives
      x_list = '{32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000,
                 32'h7fc00000, 32'h7f800001, 32'hffffffff, 32'h00000001,
                 32'h007fffff, 32'h00800000, 32'h3f800000, 32'h40800000,
                 32'h7f7fffff, 32'hbf800000, 32'hbf6eb3bc, 32'hbf6eb3be,
                 32'h3e800000, 32'h55555555, 32'haaaaaaaa, 32'h5fb759de,
                 32'hbebeb3be};
      send_phase(0, 0, x_list.size());

      for (int ph = 0; ph < 4; ph++) begin
         for (int i = 0; i < 420; i++) x_list.push_back(pick_x());
         case (ph)
            0:       send_phase(0, 0, 420);
            1:       send_phase(56, 0, 420);
            2:       send_phase(0, 56, 420);
            default: send_phase(6, 6, 420);
         endcase
      end
      @(posedge clock);
      req_valid <= 1'b0;
      stall_pct = 20;

      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("Ran 1701 inputs (specials, subnormals, negatives, random bits) through");
      $display("four idle/stall mixes; %0d results checked.", seen_count);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("FAIL");
      $finish;
   end

endmodule

### fast_inverse_square_root_unit.f
rtl/core/fisr_pkg.sv
rtl/core/fisr_fmul.sv
rtl/core/fisr_fsub.sv
rtl/core/fast_inverse_square_root_unit.sv
rtl/core/fisr_checker.sv
dv/rsqrt_checker.sv
dv/testbench.sv
